### rtl/core/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg: shared types and constants for the clap pattern detector
// Payload structs, configuration and session state, register indexes.
// ----------------------------------------------------------------------------
package cpd_pkg;

  localparam int SAMPLE_W = 10;
  localparam int COUNT_W  = 4;
  localparam int WIN_W    = 16;
  localparam int HOLD_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAP_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_CLAPS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_MS     = 3'd5;

  // Reset values of the configuration registers
  localparam logic [WIN_W-1:0]    WINDOW_MS_RST      = 16'd500;
  localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = 10'd220;
  localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RST  = 10'd100;
  localparam logic [COUNT_W-1:0]  CLAP_LIMIT_RST     = 4'd4;
  localparam logic [COUNT_W-1:0]  MATCH_CLAPS_RST    = 4'd4;
  localparam logic [HOLD_W-1:0]   HOLDOFF_MS_RST     = 8'd40;

  localparam logic ACTION_SAMPLE = 1'b0;
  localparam logic ACTION_TICK   = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [WIN_W-1:0]   WIN_MAX   = '1;

  typedef struct packed {
    logic                action;
    logic [SAMPLE_W-1:0] sample;
  } cpd_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] clap_count;
    logic               output_level;
    logic               fired;
  } cpd_out_t;

  typedef struct packed {
    logic [WIN_W-1:0]    window_ms;
    logic [SAMPLE_W-1:0] high_threshold;
    logic [SAMPLE_W-1:0] low_threshold;
    logic [COUNT_W-1:0]  clap_limit;
    logic [COUNT_W-1:0]  match_claps;
    logic [HOLD_W-1:0]   holdoff_ms;
  } cpd_cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] session_claps;
    logic               above_flag;
    logic [WIN_W-1:0]   window_elapsed;
    logic [HOLD_W-1:0]  holdoff_left;
    logic               drive_level;
  } cpd_state_t;

endpackage

### rtl/core/clap_pattern_detector.sv
// ----------------------------------------------------------------------------
// clap_pattern_detector: Schmitt-trigger clap counter
// A transfer that ends a session is held in the input register, its result in the result register.
// Throughput: one sample or tick per cycle; input stalls only while a result
// waits on a receiver that is not ready.
// Reset (synchronous, rst_n low): session state cleared, output level low,
// registers back to defaults, both channels empty.
// ----------------------------------------------------------------------------
module clap_pattern_detector #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample / tick channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  cpd_pkg::cpd_in_t                    in_data,
  // session result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output cpd_pkg::cpd_out_t                   out_data,
  // register writes
  input  logic                                cfg_we,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cpd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import cpd_pkg::*;

  // Input register: holds one accepted transfer until the step unit takes it.
  logic       in_valid_r;
  cpd_in_t    in_data_r;
  // Result register: parts the step from the downstream handshake.
  logic       out_valid_r;
  cpd_out_t   out_data_r;
  // Live session state and configuration.
  cpd_state_t st_r;
  cpd_state_t st_nxt;
  cpd_cfg_t   cfg_r;

  logic       step_res_valid;
  cpd_out_t   step_res;
  logic       advance;

  // The held item is processed when the result register is free or drains
  // in this same cycle; items that end no session leave no result but wait too.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  cpd_step #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_step (
    .item      (in_data_r),
    .cfg       (cfg_r),
    .st        (st_r),
    .st_nxt    (st_nxt),
    .res_valid (step_res_valid),
    .res       (step_res)
  );

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ms      <= WINDOW_MS_RST;
      cfg_r.high_threshold <= HIGH_THRESHOLD_RST;
      cfg_r.low_threshold  <= LOW_THRESHOLD_RST;
      cfg_r.clap_limit     <= CLAP_LIMIT_RST;
      cfg_r.match_claps    <= MATCH_CLAPS_RST;
      cfg_r.holdoff_ms     <= HOLDOFF_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_MS:      cfg_r.window_ms      <= cfg_wdata[WIN_W-1:0];
        CFG_HIGH_THRESHOLD: cfg_r.high_threshold <= cfg_wdata[SAMPLE_W-1:0];
        CFG_LOW_THRESHOLD:  cfg_r.low_threshold  <= cfg_wdata[SAMPLE_W-1:0];
        CFG_CLAP_LIMIT:     cfg_r.clap_limit     <= cfg_wdata[COUNT_W-1:0];
        CFG_MATCH_CLAPS:    cfg_r.match_claps    <= cfg_wdata[COUNT_W-1:0];
        CFG_HOLDOFF_MS:     cfg_r.holdoff_ms     <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Control: input and result valid flags, session state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end

      if (advance && step_res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance && step_res_valid) begin
      out_data_r <= step_res;
    end
  end

`ifndef ASSERT_OFF
  // A finished session leaves the detector cleared and armed.
  a_session_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && step_res_valid) |=>
      (st_r.session_claps == '0 && !st_r.above_flag &&
       st_r.window_elapsed == '0 && st_r.holdoff_left == '0))
    else $error("session state not cleared after result");

  // Output level only moves together with a result transfer.
  a_level_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.drive_level != $past(st_r.drive_level)) |->
      $past(advance && step_res_valid))
    else $error("drive level changed without a session result");

  // A pending result carries the current drive level.
  a_level_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.output_level == st_r.drive_level))
    else $error("result level differs from drive level");

  // Holdoff only runs after a counted clap with the trigger latched.
  a_holdoff_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.holdoff_left != '0) |-> (st_r.above_flag && st_r.session_claps != '0))
    else $error("holdoff running without a latched clap");
`endif

endmodule

### rtl/core/cpd_step.sv
// ----------------------------------------------------------------------------
// cpd_step: one detector step
// Next session state and optional session result for one sample or tick.
// ----------------------------------------------------------------------------
module cpd_step #(
  parameter int SAMPLE_BITS = 10
) (
  input  cpd_pkg::cpd_in_t    item,
  input  cpd_pkg::cpd_cfg_t   cfg,
  input  cpd_pkg::cpd_state_t st,
  output cpd_pkg::cpd_state_t st_nxt,
  output logic                res_valid,
  output cpd_pkg::cpd_out_t   res
);
  import cpd_pkg::*;

  localparam int CW = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_BITS-1:0] CENTER = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [SAMPLE_BITS-1:0] smp;
  logic [SAMPLE_BITS-1:0] dev;
  logic [CW-1:0]          dev_w;
  logic [CW-1:0]          hi_w;
  logic [CW-1:0]          lo_w;
  logic                   is_clap;
  logic                   is_rearm;
  logic [COUNT_W-1:0]     claps_inc;
  logic [WIN_W-1:0]       win_inc;
  logic [HOLD_W-1:0]      hold_dec;
  logic                   finish;
  logic                   fire;
  cpd_state_t             mid;

  assign smp      = SAMPLE_BITS'(item.sample);
  assign dev      = (smp >= CENTER) ? (smp - CENTER) : (CENTER - smp);
  assign dev_w    = CW'(dev);
  assign hi_w     = CW'(cfg.high_threshold);
  assign lo_w     = CW'(cfg.low_threshold);
  assign is_clap  = (dev_w > hi_w) && !st.above_flag;
  assign is_rearm = (dev_w < lo_w) && st.above_flag;

  assign claps_inc = (st.session_claps != COUNT_MAX) ? st.session_claps + 1'b1
                                                     : st.session_claps;
  assign win_inc   = (st.window_elapsed != WIN_MAX) ? st.window_elapsed + 1'b1
                                                    : st.window_elapsed;
  assign hold_dec  = st.holdoff_left - 1'b1;

  always_comb begin
    mid    = st;
    finish = 1'b0;
    if (item.action == ACTION_TICK) begin
      if (st.holdoff_left != '0) begin
        mid.holdoff_left = hold_dec;
        if (hold_dec == '0) begin
          mid.window_elapsed = '0;
          finish = (st.session_claps >= cfg.clap_limit);
        end
      end else begin
        mid.window_elapsed = win_inc;
        finish = (win_inc >= cfg.window_ms);
      end
    end else if (st.holdoff_left == '0) begin
      if (is_clap) begin
        mid.above_flag     = 1'b1;
        mid.session_claps  = claps_inc;
        mid.window_elapsed = '0;
        mid.holdoff_left   = cfg.holdoff_ms;
        // zero holdoff ends on the clap itself
        if (cfg.holdoff_ms == '0) begin
          finish = (claps_inc >= cfg.clap_limit);
        end
      end else if (is_rearm) begin
        mid.above_flag = 1'b0;
      end
    end
  end

  assign fire = (mid.session_claps == cfg.match_claps);

  always_comb begin
    st_nxt           = mid;
    res.clap_count   = mid.session_claps;
    res.fired        = fire;
    res.output_level = mid.drive_level ^ fire;
    res_valid        = finish;
    if (finish) begin
      st_nxt.session_claps  = '0;
      st_nxt.above_flag     = 1'b0;
      st_nxt.window_elapsed = '0;
      st_nxt.holdoff_left   = '0;
      st_nxt.drive_level    = mid.drive_level ^ fire;
    end
  end

endmodule
